// ===== design/mcdw_pkg.sv =====
package mcdw_pkg;

	localparam int MCDW_MAX_CLIENTS = 256;
	localparam int MCDW_TIME_BITS   = 32;

	localparam int ROUND_W = 16;
	localparam logic [ROUND_W-1:0] ROUND_MAX = '1;

	// command codes
	localparam logic [1:0] CMD_REFRESH = 2'd0;
	localparam logic [1:0] CMD_ROUND   = 2'd1;
	localparam logic [1:0] CMD_CHECK   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ACTIVE_COUNT    = 2'd0;
	localparam logic [1:0] REG_DEADLINE_MS     = 2'd1;
	localparam logic [1:0] REG_REQUIRED_ROUNDS = 2'd2;
	localparam logic [1:0] REG_QUOTA_OFF       = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  client_id;
		logic [31:0] time_ms;
	} mcdw_in_t;

	typedef struct packed {
		logic       expired;
		logic [7:0] expired_id;
		logic       all_done;
	} mcdw_out_t;

	// what the shared compare unit tells the sequencer
	typedef struct packed {
		logic               late;
		logic               short_rounds;
		logic [ROUND_W-1:0] round_next;
	} mcdw_cmp_t;

endpackage

// ===== design/multi_client_deadline_watchdog_top.sv =====
// Per-client deadline watchdog. An item is taken when start is high and busy is low.
// A refresh or round event for a client below MAX_CLIENTS does a read-modify-write of
// that client's table entry, holding busy high while the entry is written back; an
// event for a higher client or an unused command is dropped with busy staying low. A
// check at time time_ms reads the table one entry per cycle through its single read
// port, over the n = min(active_count, MAX_CLIENTS) watched clients, and puts its word
// on result with result_valid high for exactly one cycle: result_valid rises once the
// last entry read is compared, or with no read at all when n is 0, and busy drops at
// that same edge. The receiver cannot hold the word off, so it must capture it when
// result_valid is high. Right after reset the block clears its table, one entry per
// cycle, and keeps busy high until it is clear; configuration writes are taken at
// any time (cfg_ready is always high) but should only be made while busy is low.
module multi_client_deadline_watchdog_top import mcdw_pkg::*; #(
	parameter int MAX_CLIENTS = MCDW_MAX_CLIENTS,
	parameter int TIME_BITS   = MCDW_TIME_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  mcdw_in_t    item,
	output logic        result_valid,
	output mcdw_out_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CW   = $clog2(MAX_CLIENTS + 1);
	localparam int NW   = (CW > 9) ? CW : 9;
	localparam int IDCW = (CW > 8) ? CW : 8;
	localparam int DW   = TIME_BITS + ROUND_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EVT   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;

	logic [2:0] state_q;

	// configuration
	logic [8:0]         active_count_q;
	logic [31:0]        deadline_ms_q;
	logic [ROUND_W-1:0] required_rounds_q;
	logic               quota_off_q;

	// latched item
	logic [1:0]           cmd_q;
	logic [AW-1:0]        id_q;
	logic [TIME_BITS-1:0] t_q;

	// scan control
	logic [AW-1:0] clr_idx_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] iss_idx_q;
	logic          pend_s1;
	logic [CW-1:0] pend_idx_s1;
	logic          exp_q;
	logic [7:0]    exp_id_q;
	logic          done_q;

	logic      result_valid_q;
	mcdw_out_t result_q;

	// table port
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] rd_data;

	mcdw_cmp_t cmp;

	logic          accept;
	logic          id_ok;
	logic [CW-1:0] n_next;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign id_ok     = IDCW'(item.client_id) < IDCW'(MAX_CLIENTS);
	assign n_next    = (NW'(active_count_q) > NW'(MAX_CLIENTS)) ? CW'(MAX_CLIENTS)
	                                                             : CW'(active_count_q);

	mcdw_table #(
		.DEPTH (MAX_CLIENTS),
		.AW    (AW),
		.DW    (DW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mcdw_cmp #(
		.TIME_BITS (TIME_BITS)
	) u_cmp (
		.last_refresh    (rd_data[TIME_BITS-1:0]),
		.deadline        (TIME_BITS'(deadline_ms_q)),
		.now             (t_q),
		.round_count     (rd_data[DW-1:TIME_BITS]),
		.required_rounds (required_rounds_q),
		.res             (cmp)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = iss_idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = id_q;
		wr_data = rd_data;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = '0;
			end
			S_IDLE: begin
				rd_en   = accept && id_ok &&
				          (item.cmd == CMD_REFRESH || item.cmd == CMD_ROUND);
				rd_addr = AW'(item.client_id);
			end
			S_EVT: begin
				if (cmd_q == CMD_REFRESH) begin
					wr_en   = !cmp.late;
					wr_data = {rd_data[DW-1:TIME_BITS], t_q};
				end else begin
					wr_en   = !quota_off_q;
					wr_data = {cmp.round_next, rd_data[TIME_BITS-1:0]};
				end
			end
			S_SCAN: begin
				rd_en = (iss_idx_q < n_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q    <= 9'd1;
			deadline_ms_q     <= '0;
			required_rounds_q <= '0;
			quota_off_q       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE_COUNT:    active_count_q    <= cfg_data[8:0];
				REG_DEADLINE_MS:     deadline_ms_q     <= cfg_data;
				REG_REQUIRED_ROUNDS: required_rounds_q <= cfg_data[ROUND_W-1:0];
				REG_QUOTA_OFF:       quota_off_q       <= cfg_data[0];
				default:             quota_off_q       <= quota_off_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_idx_q      <= '0;
			iss_idx_q      <= '0;
			pend_s1        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == AW'(MAX_CLIENTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_CHECK) begin
							state_q   <= S_SCAN;
							iss_idx_q <= '0;
							pend_s1   <= 1'b0;
						end else if (rd_en) begin
							state_q <= S_EVT;
						end
					end
				end
				S_EVT: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						iss_idx_q <= iss_idx_q + 1'b1;
					end
					if (!pend_s1 && iss_idx_q == n_q) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			cmd_q    <= item.cmd;
			id_q     <= AW'(item.client_id);
			t_q      <= TIME_BITS'(item.time_ms);
			n_q      <= n_next;
			exp_q    <= 1'b0;
			exp_id_q <= '0;
			done_q   <= !quota_off_q;
		end
		if (state_q == S_SCAN) begin
			pend_idx_s1 <= iss_idx_q;
			if (pend_s1) begin
				// first late client wins, rounds are checked over every client
				if (cmp.late && !exp_q) begin
					exp_q    <= 1'b1;
					exp_id_q <= 8'(pend_idx_s1);
				end
				if (cmp.short_rounds) begin
					done_q <= 1'b0;
				end
			end
			if (!pend_s1 && iss_idx_q == n_q) begin
				result_q.expired    <= exp_q;
				result_q.expired_id <= exp_id_q;
				result_q.all_done   <= done_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== design/mcdw_table.sv =====
module mcdw_table import mcdw_pkg::*; #(
	parameter int DEPTH = MCDW_MAX_CLIENTS,
	parameter int AW    = 8,
	parameter int DW    = MCDW_TIME_BITS + ROUND_W
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/mcdw_cmp.sv =====
module mcdw_cmp import mcdw_pkg::*; #(
	parameter int TIME_BITS = MCDW_TIME_BITS
) (
	input  logic [TIME_BITS-1:0] last_refresh,
	input  logic [TIME_BITS-1:0] deadline,
	input  logic [TIME_BITS-1:0] now,
	input  logic [ROUND_W-1:0]   round_count,
	input  logic [ROUND_W-1:0]   required_rounds,
	output mcdw_cmp_t            res
);

	logic [TIME_BITS:0] limit;

	// one bit wider so the sum never wraps
	assign limit = {1'b0, last_refresh} + {1'b0, deadline};

	always_comb begin
		res.late         = limit < {1'b0, now};
		res.short_rounds = round_count < required_rounds;
		res.round_next   = (round_count == ROUND_MAX) ? round_count : round_count + 1'b1;
	end

endmodule
